@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rstn is low.
`define EMDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("emdc checker: same-cycle property failed");

// Next-cycle implication, disabled while rstn is low.
`define EMDC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("emdc checker: next-cycle property failed");

`endif

@@ rtl/core/emdc_pkg.sv @@
// Package for the encoder motor drive calibrator: words, codes and duty arithmetic.
package emdc_pkg;

    localparam logic [15:0] PERIOD_TOP_RESET = 16'd3999;
    localparam logic [6:0]  TEST_DUTY_RESET  = 7'd15;
    localparam logic [14:0] THRESHOLD_RESET  = 15'd10;
    localparam logic [6:0]  DUTY_MAX         = 7'd100;
    // ceil(2^30 / 100): floor(x / 100) == (x * RECIP_100) >> 30 for x < 2^23
    localparam logic [23:0] RECIP_100        = 24'd10737419;

    localparam logic [2:0] MODE_TICK      = 3'd0;
    localparam logic [2:0] MODE_SET_DUTY  = 3'd1;
    localparam logic [2:0] MODE_CALIBRATE = 3'd2;
    localparam logic [2:0] MODE_RETURN    = 3'd3;
    localparam logic [2:0] MODE_RESET_CNT = 3'd4;
    localparam logic [2:0] MODE_FORWARD   = 3'd5;
    localparam logic [2:0] MODE_BACKWARD  = 3'd6;

    localparam logic [1:0] REG_PERIOD_TOP = 2'd0;
    localparam logic [1:0] REG_TEST_DUTY  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CAL  = 2'd1,
        PH_RET  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       enc_a;
        logic       enc_b;
        logic [9:0] duty_percent;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic [15:0]        missed_steps;
        logic               dir_pin;
        logic               drive_on;
        logic [15:0]        compare_value;
        logic               busy_res;
    } out_word_t;

    // Front stage A: duty product taken at accept
    typedef struct packed {
        logic [2:0]  mode;
        logic        enc_a;
        logic        enc_b;
        logic        duty_on;
        logic [22:0] prod;
    } prod_word_t;

    // Front stage B: compare level ready for the sequencer
    typedef struct packed {
        logic [2:0]  mode;
        logic        enc_a;
        logic        enc_b;
        logic        duty_on;
        logic [15:0] cmp;
    } dec_word_t;

    // Configuration view seen by the sequencer
    typedef struct packed {
        logic        test_on;
        logic [15:0] test_cmp;
        logic [14:0] threshold;
    } cfg_view_t;

    function automatic logic [6:0] duty_clamp(input logic [9:0] duty);
        logic [6:0] res;
        if (duty > {3'b000, DUTY_MAX}) begin
            res = DUTY_MAX;
        end else begin
            res = duty[6:0];
        end
        return res;
    endfunction

    function automatic logic [22:0] duty_prod(input logic [15:0] top, input logic [6:0] duty);
        logic [23:0] p;
        p = ({7'd0, {1'b0, top} + 17'd1}) * {17'd0, duty};
        return p[22:0];
    endfunction

    function automatic logic [15:0] duty_cmp(input logic [22:0] prod);
        logic [46:0] m;
        logic [16:0] q;
        logic [16:0] qm1;
        m   = {24'd0, prod} * {23'd0, RECIP_100};
        q   = m[46:30];
        qm1 = q - 17'd1;
        return (q == 17'd0) ? 16'd0 : qm1[15:0];
    endfunction

endpackage

@@ rtl/core/emdc_cfg.sv @@
// Configuration registers and the precomputed test-duty compare level.
module emdc_cfg
    import emdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic [15:0] period_top,
    output cfg_view_t   cfg_view
);

    logic [15:0] period_top_reg;
    logic [6:0]  test_duty_reg;
    logic [14:0] threshold_reg;
    logic [22:0] test_prod_reg;
    logic [15:0] test_cmp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_top_reg <= PERIOD_TOP_RESET;
            test_duty_reg  <= TEST_DUTY_RESET;
            threshold_reg  <= THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PERIOD_TOP: period_top_reg <= cfg_data;
                REG_TEST_DUTY:  test_duty_reg  <= cfg_data[6:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // the test compare is refreshed after a write via test_prod_reg, then test_cmp_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_prod_reg <= duty_prod(PERIOD_TOP_RESET, TEST_DUTY_RESET);
            test_cmp_reg  <= duty_cmp(duty_prod(PERIOD_TOP_RESET, TEST_DUTY_RESET));
        end else begin
            test_prod_reg <= duty_prod(period_top_reg,
                                       duty_clamp({3'b000, test_duty_reg}));
            test_cmp_reg  <= duty_cmp(test_prod_reg);
        end
    end

    assign period_top         = period_top_reg;
    assign cfg_view.test_on   = (test_duty_reg != 7'd0);
    assign cfg_view.test_cmp  = test_cmp_reg;
    assign cfg_view.threshold = threshold_reg;

endmodule

@@ rtl/core/emdc_front.sv @@
// Input stages: duty product at accept, then divide by 100 into a compare level.
module emdc_front
    import emdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    input  logic [15:0] period_top,
    output logic        dec_valid,
    input  logic        dec_ready,
    output dec_word_t   dec_data
);

    logic       a_valid_reg;
    prod_word_t a_reg;
    logic       b_valid_reg;
    dec_word_t  b_reg;
    logic       ready_a;
    logic       ready_b;

    assign ready_b = !b_valid_reg || dec_ready;
    assign ready_a = !a_valid_reg || ready_b;
    assign s_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (ready_a) a_valid_reg <= s_valid;
            if (ready_b) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && s_valid) begin
            a_reg.mode    <= s_data.mode;
            a_reg.enc_a   <= s_data.enc_a;
            a_reg.enc_b   <= s_data.enc_b;
            a_reg.duty_on <= (s_data.duty_percent != 10'd0);
            a_reg.prod    <= duty_prod(period_top, duty_clamp(s_data.duty_percent));
        end
        if (ready_b && a_valid_reg) begin
            b_reg.mode    <= a_reg.mode;
            b_reg.enc_a   <= a_reg.enc_a;
            b_reg.enc_b   <= a_reg.enc_b;
            b_reg.duty_on <= a_reg.duty_on;
            b_reg.cmp     <= duty_cmp(a_reg.prod);
        end
    end

    assign dec_valid = b_valid_reg;
    assign dec_data  = b_reg;

endmodule

@@ rtl/core/emdc_core.sv @@
// Quadrature decode, command handling and calibration sequencer with result register.
module emdc_core
    import emdc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dec_word_t in_data,
    input  cfg_view_t cfg_view,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic        prev_a_reg, prev_a_next;
    logic        prev_b_reg, prev_b_next;
    logic [31:0] pos_count_reg, pos_count_next;
    logic [15:0] miss_count_reg, miss_count_next;
    logic        polarity_reg, polarity_next;
    logic        going_back_reg, going_back_next;
    logic        drive_reg, drive_next;
    logic [15:0] compare_reg, compare_next;
    phase_t      phase_reg, phase_next;
    logic        m_valid_reg;
    out_word_t   m_data_reg;
    out_word_t   m_data_next;

    logic        fire;
    logic        step_up;
    logic        step_down;
    logic [31:0] pos_dec;
    logic [31:0] pos_mag;
    logic        pos_neg;
    logic        pos_zero;
    logic        cal_done;
    logic        cal_step;
    logic        ret_step;

    assign in_ready = !m_valid_reg || m_ready;
    assign fire     = in_valid && in_ready;

    assign step_up   = (in_data.enc_a != prev_b_reg);
    assign step_down = (in_data.enc_b != prev_a_reg);

    always_comb begin
        pos_dec = pos_count_reg;
        if (step_up && !step_down) begin
            pos_dec = pos_count_reg + 32'd1;
        end else if (step_down && !step_up) begin
            pos_dec = pos_count_reg - 32'd1;
        end
    end

    assign pos_neg  = pos_dec[31];
    assign pos_zero = (pos_dec == 32'd0);
    assign pos_mag  = pos_neg ? (32'd0 - pos_dec) : pos_dec;
    assign cal_done = (pos_mag >= {17'd0, cfg_view.threshold});

    // next state
    always_comb begin
        prev_a_next     = in_data.enc_a;
        prev_b_next     = in_data.enc_b;
        pos_count_next  = pos_dec;
        miss_count_next = miss_count_reg;
        polarity_next   = polarity_reg;
        going_back_next = going_back_reg;
        drive_next      = drive_reg;
        compare_next    = compare_reg;
        phase_next      = phase_reg;
        cal_step        = 1'b0;
        ret_step        = 1'b0;

        if ((in_data.enc_a != prev_a_reg) && (in_data.enc_b != prev_b_reg)) begin
            miss_count_next = miss_count_reg + 16'd1;
        end

        unique case (phase_reg)
            PH_CAL: cal_step = 1'b1;
            PH_RET: ret_step = 1'b1;
            default: begin
                // idle, and the unused phase code: commands are taken
                phase_next = PH_IDLE;
                case (in_data.mode)
                    MODE_SET_DUTY: begin
                        drive_next   = in_data.duty_on;
                        compare_next = in_data.cmp;
                    end
                    MODE_CALIBRATE: begin
                        going_back_next = 1'b0;
                        drive_next      = cfg_view.test_on;
                        compare_next    = cfg_view.test_cmp;
                        phase_next      = PH_CAL;
                        cal_step        = 1'b1;
                    end
                    MODE_RETURN: begin
                        phase_next = PH_RET;
                        ret_step   = 1'b1;
                    end
                    MODE_RESET_CNT: pos_count_next  = 32'd0;
                    MODE_FORWARD:   going_back_next = 1'b0;
                    MODE_BACKWARD:  going_back_next = 1'b1;
                    default: ;
                endcase
            end
        endcase

        if (cal_step && cal_done) begin
            polarity_next = polarity_reg ^ pos_neg;
            phase_next    = PH_RET;
            ret_step      = 1'b1;
        end

        if (ret_step) begin
            if (pos_zero) begin
                going_back_next = 1'b0;
                drive_next      = 1'b0;
                compare_next    = 16'd0;
                phase_next      = PH_IDLE;
            end else begin
                going_back_next = !pos_neg;
                drive_next      = cfg_view.test_on;
                compare_next    = cfg_view.test_cmp;
            end
        end
    end

    // outputs
    always_comb begin
        m_data_next.position      = $signed(pos_count_next);
        m_data_next.missed_steps  = miss_count_next;
        m_data_next.dir_pin       = polarity_next ^ going_back_next;
        m_data_next.drive_on      = drive_next;
        m_data_next.compare_value = compare_next;
        m_data_next.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg     <= 1'b0;
            prev_b_reg     <= 1'b0;
            pos_count_reg  <= 32'd0;
            miss_count_reg <= 16'd0;
            polarity_reg   <= 1'b0;
            going_back_reg <= 1'b0;
            drive_reg      <= 1'b0;
            compare_reg    <= 16'd0;
            phase_reg      <= PH_IDLE;
            m_valid_reg    <= 1'b0;
        end else begin
            if (fire) begin
                prev_a_reg     <= prev_a_next;
                prev_b_reg     <= prev_b_next;
                pos_count_reg  <= pos_count_next;
                miss_count_reg <= miss_count_next;
                polarity_reg   <= polarity_next;
                going_back_reg <= going_back_next;
                drive_reg      <= drive_next;
                compare_reg    <= compare_next;
                phase_reg      <= phase_next;
            end
            if (in_ready) m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/encoder_motor_drive_calibrator_unit.sv @@
// Top level of the encoder motor drive calibrator.
// Usage:
//   s_valid/s_ready/s_data carry one input word per clock tick: command mode,
//   encoder levels A and B, and the requested duty percent.
//   m_valid/m_ready/m_data return one result word per input word: position,
//   missed steps, direction pin, drive enable, PWM compare level, busy flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write period_top (0), test_duty (1)
//   and settle_threshold (2); cfg_ready is always high. Write only while idle.
// The path from input accept to result valid has three registered stages: one
//   forms the duty product, one divides it by 100 with a reciprocal multiply,
//   and the third decodes the encoder and steps the calibration sequencer into
//   the result register. Throughput is one word per cycle while the receiver does not stall.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
//   counts, direction and sequencer state, and empties the pipeline.
// When the receiver stalls, the result word holds and the stages behind it
//   keep filling; s_ready drops once all three stages hold a word.
module encoder_motor_drive_calibrator_unit
    import emdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] period_top;
    cfg_view_t   cfg_view;
    logic        dec_valid;
    logic        dec_ready;
    dec_word_t   dec_data;

    emdc_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .period_top (period_top),
        .cfg_view   (cfg_view)
    );

    emdc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .period_top (period_top),
        .dec_valid  (dec_valid),
        .dec_ready  (dec_ready),
        .dec_data   (dec_data)
    );

    emdc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (dec_valid),
        .in_ready (dec_ready),
        .in_data  (dec_data),
        .cfg_view (cfg_view),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/core/emdc_checker.sv @@
// Port-level checker for the encoder motor drive calibrator, with its bind.
`include "assert_macros.svh"

module emdc_checker
    import emdc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    logic off_cmp_ok;

    assign off_cmp_ok = m_data.drive_on || (m_data.compare_value == 16'd0);

    `EMDC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `EMDC_ASSERT_NXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `EMDC_ASSERT_IMP(a_off_zero_cmp, aclk, aresetn, m_valid, off_cmp_ok)
    `EMDC_ASSERT_NXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind encoder_motor_drive_calibrator_unit emdc_checker u_emdc_checker (.*);
